// ----- hw/rtl/bf16_fp32_multi_operand_sum_macros.svh -----
// assertion macros for the bf16/fp32 multi-operand sum block
// no dependencies
`ifndef BF16_FP32_MULTI_OPERAND_SUM_MACROS_SVH
`define BF16_FP32_MULTI_OPERAND_SUM_MACROS_SVH

// implication checked on every rising clock edge, disabled in reset
`define BFS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define BFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bfs_pkg.sv -----
// types, constants and fp32 helper functions for the multi-operand sum
// no dependencies
package bfs_pkg;

    localparam int unsigned NumFields = 8;
    localparam logic [31:0] DefaultNan = 32'hffc0_0000;
    localparam logic [31:0] QuietBit = 32'h0040_0000;
    localparam logic [15:0] Bf16Nan = 16'hffff;
    localparam logic [16:0] RoundBias = 17'h0_7fff;

    localparam logic [0:0] TypeBf16 = 1'b0;
    localparam logic [0:0] TypeFp32 = 1'b1;

    localparam logic [0:0] RegBufferCount = 1'b0;
    localparam logic [0:0] RegDataType = 1'b1;

    typedef struct packed {
        logic [31:0] operand_0;
        logic [31:0] operand_1;
        logic [31:0] operand_2;
        logic [31:0] operand_3;
        logic [31:0] operand_4;
        logic [31:0] operand_5;
        logic [31:0] operand_6;
        logic [31:0] operand_7;
        logic        last_element;
    } in_word_t;

    typedef struct packed {
        logic [31:0] sum_bits;
        logic        last_out;
    } out_word_t;

    // first half of an fp32 add: aligned operands
    typedef struct packed {
        logic        special;    // result already known
        logic [31:0] special_val;
        logic        sign_big;
        logic        eff_sub;
        logic [7:0]  exp_big;    // biased exponent, 1 for subnormals
        logic [26:0] mant_big;   // hidden bit, 23 fraction, 3 guard bits
        logic [26:0] mant_small; // shifted, sticky in lsb
    } fadd_mid_t;

    function automatic logic is_nan32(input logic [31:0] b);
        return (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    endfunction

    function automatic fadd_mid_t fadd_align(input logic [31:0] a, input logic [31:0] b);
        fadd_mid_t   m;
        logic        a_big;
        logic [31:0] x;
        logic [31:0] y;
        logic [7:0]  ex;
        logic [7:0]  ey;
        logic [7:0]  d;
        logic [26:0] my;
        logic [26:0] sh;
        logic        sticky;
        a_big = (a[30:0] >= b[30:0]);
        x = a_big ? a : b;
        y = a_big ? b : a;
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d = ex - ey;
        my = {(y[30:23] != 8'd0), y[22:0], 3'b000};
        if (d > 8'd27)
        begin
            sh = 27'd0;
            sticky = (my != 27'd0);
        end
        else
        begin
            sh = my >> d;
            sticky = ((sh << d) != my);
        end
        m.sign_big = x[31];
        m.eff_sub = a[31] ^ b[31];
        m.exp_big = ex;
        m.mant_big = {(x[30:23] != 8'd0), x[22:0], 3'b000};
        m.mant_small = {sh[26:1], sh[0] | sticky};
        m.special = 1'b0;
        m.special_val = 32'd0;
        if (is_nan32(a))
        begin
            m.special = 1'b1;
            m.special_val = a | QuietBit;
        end
        else if (is_nan32(b))
        begin
            m.special = 1'b1;
            m.special_val = b | QuietBit;
        end
        else if (a[30:23] == 8'hff && b[30:23] == 8'hff)
        begin
            m.special = 1'b1;
            m.special_val = (a[31] != b[31]) ? DefaultNan : a;
        end
        else if (x[30:23] == 8'hff)
        begin
            m.special = 1'b1;
            m.special_val = x;
        end
        else if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
        begin
            m.special = 1'b1;
            m.special_val = {a[31] & b[31], 31'd0};
        end
        return m;
    endfunction

    function automatic logic [31:0] fadd_norm(input fadd_mid_t m);
        logic [27:0] s;
        logic [9:0]  e;
        logic [4:0]  lz;
        logic [27:0] n;
        logic [23:0] kept;
        logic        g;
        logic        st;
        logic [24:0] r;
        logic [31:0] res;
        if (m.eff_sub)
            s = {1'b0, m.mant_big} - {1'b0, m.mant_small};
        else
            s = {1'b0, m.mant_big} + {1'b0, m.mant_small};
        e = {2'b00, m.exp_big};
        if (s == 28'd0)
            res = 32'd0;
        else
        begin
            if (s[27])
            begin
                n = {1'b0, s[27:2], s[1] | s[0]};
                e = e + 10'd1;
            end
            else
            begin
                lz = 5'd0;
                for (int i = 26; i >= 0; i--)
                begin
                    if (s[i] && lz == 5'd0)
                        lz = 5'(26 - i) + 5'd1;
                end
                lz = lz - 5'd1;
                if ({5'd0, lz} >= e)
                    lz = 5'(e - 10'd1);
                n = s << lz;
                e = e - {5'd0, lz};
            end
            kept = n[26:3];
            g = n[2];
            st = n[1] | n[0];
            r = {1'b0, kept} + {24'd0, g & (st | kept[0])};
            if (r[24])
            begin
                r = r >> 1;
                e = e + 10'd1;
            end
            if (e >= 10'd255)
                res = {m.sign_big, 8'hff, 23'd0};
            else if (!r[23])
                res = {m.sign_big, 8'd0, r[22:0]};
            else
                res = {m.sign_big, e[7:0], r[22:0]};
        end
        if (m.special)
            res = m.special_val;
        return res;
    endfunction

endpackage

// ----- hw/rtl/bfs_add_stage.sv -----
// one fp32 adder of the chain, split over two register stages
// depends on bfs_pkg
module bfs_add_stage
    import bfs_pkg::*;
#(
    parameter int unsigned STAGE = 1
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    input  logic [3:0]  count,
    input  logic [31:0] acc,
    input  in_word_t    word,
    output logic        valid_out,
    output logic [3:0]  count_out,
    output logic [31:0] acc_out,
    output in_word_t    word_out
);

    fadd_mid_t   mid_reg;
    logic [31:0] acc_hold_reg;
    logic        valid_mid_reg;
    logic [3:0]  count_mid_reg;
    in_word_t    word_mid_reg;
    logic        valid_o_reg;
    logic [3:0]  count_o_reg;
    logic [31:0] acc_o_reg;
    in_word_t    word_o_reg;
    logic [31:0] op;
    logic [31:0] sum_next;

    always_comb
    begin
        case (STAGE)
            1: op = word.operand_1;
            2: op = word.operand_2;
            3: op = word.operand_3;
            4: op = word.operand_4;
            5: op = word.operand_5;
            6: op = word.operand_6;
            default: op = word.operand_7;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_mid_reg <= 1'b0;
            valid_o_reg   <= 1'b0;
        end
        else
        begin
            valid_mid_reg <= valid;
            valid_o_reg   <= valid_mid_reg;
        end
    end

    assign sum_next = fadd_norm(mid_reg);

    always_ff @(posedge clk)
    begin
        mid_reg       <= fadd_align(acc, op);
        acc_hold_reg  <= acc;
        count_mid_reg <= count;
        word_mid_reg  <= word;
        count_o_reg   <= count_mid_reg;
        word_o_reg    <= word_mid_reg;
        // stages past the count leave the accumulator alone
        acc_o_reg     <= (count_mid_reg > 4'(STAGE)) ? sum_next : acc_hold_reg;
    end

    assign valid_out = valid_o_reg;
    assign count_out = count_o_reg;
    assign acc_out   = acc_o_reg;
    assign word_out  = word_o_reg;

endmodule

// ----- hw/rtl/bf16_fp32_multi_operand_sum.sv -----
// top level of the bf16/fp32 multi-operand sum reduction
// depends on bfs_pkg, bfs_add_stage and the macros header
//
// Sums the first buffer_count operands of each word in index order with
// round-to-nearest-even fp32 adds, (((op0+op1)+op2)+...). A word is taken on
// every cycle that start is high (busy is always low). The operand limit is
// MAX_OPERANDS capped at eight. A word passes through the entry register,
// the chain of adders (one adder of two register stages per operand after
// the first) and the output register, which raises done with the result.
// The receiver cannot stall, so results leave in order and are never held.
// In bf16 mode the fp32 sum is rounded back once to bf16, any NaN giving
// 0xffff; a count of zero or one returns operand_0 unchanged (in bf16 its low half).
`include "bf16_fp32_multi_operand_sum_macros.svh"

module bf16_fp32_multi_operand_sum
    import bfs_pkg::*;
#(
    parameter int unsigned MAX_OPERANDS = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_word_t  in_word,
    output logic      done,
    output out_word_t out_word,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [3:0] cfg_data
);

    localparam int unsigned NumOps = (MAX_OPERANDS < NumFields) ? MAX_OPERANDS : NumFields;
    localparam int unsigned NumAdds = NumOps - 1;

    logic [3:0] buffer_count_reg;
    logic       data_type_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_count_reg <= 4'd2;
            data_type_reg    <= TypeBf16;
        end
        else if (cfg_we)
        begin
            if (cfg_index == RegBufferCount)
                buffer_count_reg <= cfg_data;
            else
                data_type_reg <= cfg_data[0];
        end
    end

    assign busy = 1'b0;

    // widened operands and the clamped count
    logic       bf16;
    logic [3:0] count_eff;
    in_word_t   wide;

    function automatic logic [31:0] widen(input logic [31:0] v, input logic b);
        return b ? {v[15:0], 16'd0} : v;
    endfunction

    always_comb
    begin
        bf16 = (data_type_reg == TypeBf16);
        count_eff = (buffer_count_reg > 4'(NumOps)) ? 4'(NumOps) : buffer_count_reg;
        wide = in_word;
        wide.operand_1 = widen(in_word.operand_1, bf16);
        wide.operand_2 = widen(in_word.operand_2, bf16);
        wide.operand_3 = widen(in_word.operand_3, bf16);
        wide.operand_4 = widen(in_word.operand_4, bf16);
        wide.operand_5 = widen(in_word.operand_5, bf16);
        wide.operand_6 = widen(in_word.operand_6, bf16);
        wide.operand_7 = widen(in_word.operand_7, bf16);
    end

    // entry stage: operand_0 kept raw for the pass-through case
    logic        v0_reg;
    logic [3:0]  c0_reg;
    logic [31:0] a0_reg;
    in_word_t    w0_reg;
    logic        bf0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        c0_reg  <= count_eff;
        a0_reg  <= widen(in_word.operand_0, bf16);
        w0_reg  <= wide;
        bf0_reg <= bf16;
    end

    // adder chain
    logic        vs [NumAdds+1];
    logic [3:0]  cs [NumAdds+1];
    logic [31:0] as_ [NumAdds+1];
    in_word_t    ws [NumAdds+1];

    assign vs[0]  = v0_reg;
    assign cs[0]  = c0_reg;
    assign as_[0] = a0_reg;
    assign ws[0]  = w0_reg;

    for (genvar g = 0; g < NumAdds; g++)
    begin : g_add
        bfs_add_stage #(.STAGE(g + 1)) u_add (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid     (vs[g]),
            .count     (cs[g]),
            .acc       (as_[g]),
            .word      (ws[g]),
            .valid_out (vs[g+1]),
            .count_out (cs[g+1]),
            .acc_out   (as_[g+1]),
            .word_out  (ws[g+1])
        );
    end

    // bf16 mode is carried alongside in a shift line
    logic [NumAdds*2-1:0] bf_line_reg;

    always_ff @(posedge clk)
    begin
        bf_line_reg <= {bf_line_reg[NumAdds*2-2:0], bf0_reg};
    end

    // output rounding
    logic        bfe;
    logic [31:0] acc_f;
    logic [32:0] t;
    logic [31:0] res_next;

    always_comb
    begin
        bfe = bf_line_reg[NumAdds*2-1];
        acc_f = as_[NumAdds];
        t = {1'b0, acc_f} + {16'd0, RoundBias} + {32'd0, acc_f[16]};
        if (cs[NumAdds] <= 4'd1)
            res_next = bfe ? {16'd0, ws[NumAdds].operand_0[15:0]} : ws[NumAdds].operand_0;
        else if (!bfe)
            res_next = acc_f;
        else if (is_nan32(acc_f))
            res_next = {16'd0, Bf16Nan};
        else if (t[32])
            res_next = {16'd0, Bf16Nan};
        else
            res_next = {16'd0, t[31:16]};
    end

    logic      done_reg;
    out_word_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vs[NumAdds];
    end

    always_ff @(posedge clk)
    begin
        out_reg.sum_bits <= res_next;
        out_reg.last_out <= ws[NumAdds].last_element;
    end

    assign done     = done_reg;
    assign out_word = out_reg;

    // checks
    `BFS_ASSERT_NEXT(a_out_follows, vs[NumAdds], done, "result strobe lost")
    `BFS_ASSERT_IMP(a_never_busy, start, !busy, "busy raised")
    `BFS_ASSERT_NEXT(a_bf_zero_top, vs[NumAdds] && bfe, out_word.sum_bits[31:16] == 16'd0, "bf16 upper half not zero")

endmodule

// ----- tb/bf16_fp32_multi_operand_sum_checker.sv -----
// sum checker: watches the config, input and result ports of the sum block,
// predicts every result word in fp32 / bf16 and compares it; uses bfs_pkg types
module bf16_fp32_multi_operand_sum_checker
    import bfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  in_word_t   in_word,
    input  logic       done,
    input  out_word_t  out_word,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data,
    output int         errors,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [3:0] operand_count;
    logic [0:0] elem_type;
    out_word_t  sum_q[$];

    function automatic logic nan_bits(input logic [31:0] v);
        return (v[30:23] == 8'hff) && (v[22:0] != 23'd0);
    endfunction

    // one round-to-nearest-even fp32 addition with hardware nan rules
    function automatic logic [31:0] fp32_sum(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x;
        logic [31:0] y;
        logic [63:0] big;
        logic [63:0] sm;
        logic [63:0] t;
        logic [63:0] s;
        logic [23:0] kept;
        logic [24:0] r;
        logic        g;
        logic        st;
        int          ex;
        int          ey;
        int          d;
        int          p;
        int          k;
        if (nan_bits(a))
            return a | QuietBit;
        if (nan_bits(b))
            return b | QuietBit;
        if (a[30:23] == 8'hff && b[30:23] == 8'hff)
            return (a[31] != b[31]) ? DefaultNan : a;
        if (a[30:23] == 8'hff)
            return a;
        if (b[30:23] == 8'hff)
            return b;
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
            return {a[31] & b[31], 31'd0};
        if (a[30:0] >= b[30:0])
        begin
            x = a;
            y = b;
        end
        else
        begin
            x = b;
            y = a;
        end
        ex = (x[30:23] == 8'd0) ? 1 : int'(x[30:23]);
        ey = (y[30:23] == 8'd0) ? 1 : int'(y[30:23]);
        d = ex - ey;
        // three guard bits below the fraction
        big = {37'd0, (x[30:23] != 8'd0), x[22:0], 3'b000};
        sm = {37'd0, (y[30:23] != 8'd0), y[22:0], 3'b000};
        if (d > 40)
            sm = (sm != 64'd0) ? 64'd1 : 64'd0;
        else
        begin
            t = sm >> d;
            if ((t << d) != sm)
                t[0] = 1'b1;
            sm = t;
        end
        s = (x[31] ^ y[31]) ? big - sm : big + sm;
        if (s == 64'd0)
            return 32'd0;
        p = 0;
        for (int i = 0; i < 64; i++)
            if (s[i])
                p = i;
        if (p > 26)
        begin
            k = p - 26;
            st = (s & ((64'd1 << k) - 64'd1)) != 64'd0;
            s = s >> k;
            s[0] = s[0] | st;
            ex = ex + k;
        end
        else
        begin
            // normalize, but never below the subnormal exponent
            k = 26 - p;
            if (k > ex - 1)
                k = ex - 1;
            s = s << k;
            ex = ex - k;
        end
        kept = s[26:3];
        g = s[2];
        st = s[1] | s[0];
        r = {1'b0, kept} + {24'd0, g & (st | kept[0])};
        if (r[24])
        begin
            r = r >> 1;
            ex = ex + 1;
        end
        if (ex >= 255)
            return {x[31], 8'hff, 23'd0};
        if (!r[23])
            return {x[31], 8'd0, r[22:0]};
        return {x[31], 8'(ex), r[22:0]};
    endfunction

    function automatic out_word_t predict_sum(input in_word_t w, input logic [3:0] cnt,
                                              input logic [0:0] ty);
        out_word_t   o;
        logic [31:0] ops [8];
        logic [31:0] acc;
        logic [32:0] rnd;
        int          n;
        ops = '{w.operand_0, w.operand_1, w.operand_2, w.operand_3,
                w.operand_4, w.operand_5, w.operand_6, w.operand_7};
        n = (cnt > 4'd8) ? 8 : int'(cnt);
        o.last_out = w.last_element;
        if (n <= 1)
        begin
            // count of zero or one passes operand 0 through
            o.sum_bits = (ty == TypeBf16) ? {16'd0, ops[0][15:0]} : ops[0];
            return o;
        end
        acc = (ty == TypeBf16) ? {ops[0][15:0], 16'd0} : ops[0];
        for (int i = 1; i < n; i++)
            acc = fp32_sum(acc, (ty == TypeBf16) ? {ops[i][15:0], 16'd0} : ops[i]);
        if (ty == TypeBf16)
        begin
            if (nan_bits(acc))
                acc = {16'd0, Bf16Nan};
            else
            begin
                rnd = {1'b0, acc} + 33'(RoundBias) + 33'(acc[16]);
                acc = {16'd0, rnd[31:16]};
            end
        end
        o.sum_bits = acc;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            operand_count <= 4'd2;
            elem_type <= TypeBf16;
            errors <= 0;
            pending <= 0;
            sum_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (sum_q.size() == 0)
                begin
                    $display("%0t: result word with none expected: actual %h/%b",
                             $time, out_word.sum_bits, out_word.last_out);
                    errors <= errors + 1;
                end
                else
                begin
                    want = sum_q.pop_front();
                    if (want.sum_bits !== out_word.sum_bits
                        || want.last_out !== out_word.last_out)
                    begin
                        $display("%0t: mismatch: expected %h/%b actual %h/%b", $time,
                                 want.sum_bits, want.last_out,
                                 out_word.sum_bits, out_word.last_out);
                        errors <= errors + 1;
                    end
                end
            end
            if (start && !busy)
                sum_q.push_back(predict_sum(in_word, operand_count, elem_type));
            pending <= sum_q.size();
            if (cfg_we)
            begin
                if (cfg_index == RegBufferCount)
                    operand_count <= cfg_data;
                else
                    elem_type <= cfg_data[0];
            end
        end
    end

endmodule

// ----- tb/bf16_fp32_multi_operand_sum_tb.sv -----
// testbench top for the bf16/fp32 multi-operand sum: clock, reset, config
// phases, directed and random words; depends on bfs_pkg and the checker
module bf16_fp32_multi_operand_sum_tb;
    import bfs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 300000;
    localparam int DrainCycles = 24;   // adder chain latency plus margin

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    in_word_t   in_word;
    logic       done;
    out_word_t  out_word;
    logic       cfg_we;
    logic       cfg_index;
    logic [3:0] cfg_data;
    int         errors;
    int         pending;
    int         cycles;
    logic       no_gaps;

    bf16_fp32_multi_operand_sum i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_word   (in_word),
        .done      (done),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bf16_fp32_multi_operand_sum_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_word   (in_word),
        .done      (done),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // random fp32 pattern, weighted toward the interesting corners
    function automatic logic [31:0] pick_fp32();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 15))
            0: v[30:0] = 31'd0;                               // signed zero
            1: v[30:0] = {8'hff, 23'd0};                      // infinity
            2: v[30:23] = 8'hff;                              // nan, random payload
            3: v[30:23] = 8'd0;                               // subnormal
            4: v[30:0] = {8'hfe, 23'h7fffff};                 // largest normal
            5: v[30:23] = 8'(1 + $urandom_range(0, 2));       // near subnormal border
            6: v[30:23] = 8'(253 + $urandom_range(0, 1));     // near overflow
            7, 8, 9, 10: v[30:23] = 8'(124 + $urandom_range(0, 6)); // close exponents
            default: ;
        endcase
        if (v[30:23] == 8'hff && v[22:0] == 23'd0 && $urandom_range(0, 1))
            v[0] = 1'b1;
        return v;
    endfunction

    // operand for the current element format; bf16 keeps junk in the upper half
    function automatic logic [31:0] pick_operand(input logic [0:0] ty);
        logic [31:0] f;
        logic [31:0] junk;
        f = pick_fp32();
        junk = $urandom;
        return (ty == TypeBf16) ? {junk[15:0], f[31:16]} : f;
    endfunction

    function automatic in_word_t fill_word(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] rest, input logic last);
        in_word_t w;
        w = '{a, b, rest, rest, rest, rest, rest, rest, last};
        return w;
    endfunction

    task automatic write_reg(input logic idx, input logic [3:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // wait for every word in flight to leave before touching the config
    task automatic drain();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // hold start with the word until accepted, then maybe leave a gap
    task automatic send_word(input in_word_t w);
        int gap;
        in_word = w;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        gap = 0;
        if (!no_gaps && $urandom_range(0, 1))
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic end_burst();
        start = 1'b0;
    endtask

    task automatic random_phase(input logic [3:0] cnt, input logic [0:0] ty, input int n);
        in_word_t w;
        drain();
        write_reg(RegBufferCount, cnt);
        write_reg(RegDataType, 4'(ty));
        @(negedge clk);
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            w = '{pick_operand(ty), pick_operand(ty), pick_operand(ty), pick_operand(ty),
                  pick_operand(ty), pick_operand(ty), pick_operand(ty), pick_operand(ty),
                  1'($urandom_range(0, 1))};
            send_word(w);
        end
        end_burst();
    endtask

    initial
    begin
        logic [3:0] counts [12];
        rst_n = 1'b0;
        start = 1'b0;
        in_word = '0;
        cfg_we = 1'b0;
        cfg_index = RegBufferCount;
        cfg_data = 4'd0;
        no_gaps = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset config: two bf16 operands
        send_word(fill_word(32'h0000_3f80, 32'hffff_3f80, 32'd0, 1'b1));  // 1 + 1
        send_word(fill_word(32'h0000_7f80, 32'h0000_ff80, 32'd0, 1'b0));  // inf - inf
        send_word(fill_word(32'h0000_7f7f, 32'h0000_7f7f, 32'd0, 1'b1));  // overflow
        send_word(fill_word(32'h0000_0001, 32'h0000_8001, 32'd0, 1'b0));  // subnormal cancel
        send_word(fill_word(32'h0000_3f80, 32'h0000_3b80, 32'd0, 1'b1));  // rounding tie
        end_burst();

        // fp32, all eight operands
        drain();
        write_reg(RegBufferCount, 4'd8);
        write_reg(RegDataType, 4'(TypeFp32));
        send_word(fill_word(32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
        send_word(fill_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
        send_word(fill_word(32'hffff_ffff, 32'h0000_0000, 32'h0000_0000, 1'b1));
        send_word(fill_word(32'h3f80_0000, 32'h7f80_0001, 32'h7fc0_1234, 1'b0));
        send_word(fill_word(32'h7f80_0000, 32'hff80_0000, 32'h3f80_0000, 1'b1));
        send_word(fill_word(32'h7f7f_ffff, 32'h7f7f_ffff, 32'hff7f_ffff, 1'b0));
        send_word(fill_word(32'h0000_0001, 32'h0000_0001, 32'h807f_ffff, 1'b1));
        send_word(fill_word(32'h3f80_0000, 32'h3380_0000, 32'h3380_0000, 1'b0));
        send_word(fill_word(32'h4b00_0001, 32'hcb00_0000, 32'h0000_0000, 1'b1));
        send_word(fill_word(32'h7f80_0000, 32'h7f7f_ffff, 32'hff7f_ffff, 1'b0));
        end_burst();

        // count of one passes a nan through untouched
        drain();
        write_reg(RegBufferCount, 4'd1);
        write_reg(RegDataType, 4'(TypeBf16));
        send_word(fill_word(32'habcd_7fc1, 32'h0000_3f80, 32'hffff_ffff, 1'b1));
        send_word(fill_word(32'hffff_ffff, 32'h0000_3f80, 32'h0000_0000, 1'b0));
        end_burst();

        // random phases covering counts zero to nine and fifteen, the extremes and both formats
        counts = '{4'd2, 4'd8, 4'd0, 4'd15, 4'd1, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd9, 4'd8};
        for (int ph = 0; ph < 12; ph++)
        begin
            random_phase(counts[ph], TypeBf16, 60);
            random_phase(counts[ph], TypeFp32, 60);
        end

        drain();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
